/* hw/rtl/bmpq_pkg.sv */
package bmpq_pkg;

    // Command codes carried in s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes carried in m_tuser
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int OCC_W   = 5;

    // One stored entry
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t item;
    } queue_op_t;

endpackage

/* hw/rtl/bounded_min_priority_queue.sv */
// A command's result is loaded into the output register on its transaction.
// Throughput: one command per cycle while s_tready is high; every cell of the sorted chain updates together.
// s_tready drops only while a result waits and m_tready is low.
// Reset (aresetn low, synchronous) empties the queue and the output register;
// stored entries are not cleared and are never read before being written.
module bounded_min_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] removed_value, [47:32] removed_priority,
                                   // [52:48] occupancy, [55:53] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [55:0]      m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg, m_tuser_next;

    logic                fire, is_insert, full, empty, do_insert, do_remove;
    bmpq_pkg::queue_op_t op;
    bmpq_pkg::entry_t    cell_entry [CAPACITY];
    logic                cell_keep  [CAPACITY];
    logic [CAPACITY-1:0] sorted_ok;
    logic [CNT_W+4:0]    occ_ext;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign fire      = s_tvalid && s_tready;
    assign is_insert = (s_tuser[0] == bmpq_pkg::CMD_INSERT);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign do_insert = fire && is_insert && !full;
    assign do_remove = fire && !is_insert && !empty;

    // Broadcast the command to the chain
    always_comb begin
        op.insert     = do_insert;
        op.remove     = do_remove;
        op.item.value = s_tdata[31:0];
        op.item.prio  = s_tdata[47:32];
    end

    // Row of cells, slot 0 holds the smallest priority
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        bmpq_cell u_cell (
            .aclk        (aclk),
            .op          (op),
            .occupied    (count_reg > CNT_W'(i)),
            .left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
            .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry ((i == CAPACITY - 1) ? op.item
                                              : cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
            .keep        (cell_keep[i]),
            .entry       (cell_entry[i])
        );
    end

    // Advance the occupancy count
    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign occ_ext = {5'd0, count_next};

    // Load the result register on a transaction, drop it once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            if (is_insert) begin
                m_tuser_next = full ? bmpq_pkg::STATUS_OVERFLOW : bmpq_pkg::STATUS_DONE;
            end else begin
                m_tuser_next = empty ? bmpq_pkg::STATUS_UNDERFLOW : bmpq_pkg::STATUS_DONE;
            end
            if (do_remove) begin
                m_tdata_next[31:0]  = cell_entry[0].value;
                m_tdata_next[47:32] = cell_entry[0].prio;
            end
            m_tdata_next[52:48] = occ_ext[4:0];
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Occupied slots stay in non-decreasing priority order
    always_comb begin
        sorted_ok = '1;
        for (int i = 1; i < CAPACITY; i++) begin
            if (count_reg > CNT_W'(i)) begin
                sorted_ok[i] = ($signed(cell_entry[i - 1].prio) <= $signed(cell_entry[i].prio));
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        &sorted_ok)
        else $error("chain out of priority order");

    a_overflow_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && is_insert && full |=> $stable(count_reg) && m_tvalid
            && m_tuser == bmpq_pkg::STATUS_OVERFLOW)
        else $error("overflow changed the queue");

    a_remove_done: assert property (@(posedge aclk) disable iff (!aresetn)
        do_remove |=> m_tvalid && m_tuser == bmpq_pkg::STATUS_DONE
            && count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove result wrong");

endmodule

/* hw/rtl/bmpq_cell.sv */
module bmpq_cell (
    input  logic               aclk,
    input  bmpq_pkg::queue_op_t op,
    input  logic               occupied,
    input  logic               left_keep,
    input  bmpq_pkg::entry_t   left_entry,
    input  bmpq_pkg::entry_t   right_entry,
    output logic               keep,
    output bmpq_pkg::entry_t   entry
);

    bmpq_pkg::entry_t entry_reg;
    bmpq_pkg::entry_t entry_next;

    // Hold the slot on insert when its entry leaves no later than the new one
    assign keep  = occupied && ($signed(entry_reg.prio) <= $signed(op.item.prio));
    assign entry = entry_reg;

    // Insert: hold, take the new item, or shift in from the left.
    // Remove: shift in from the right.
    always_comb begin
        entry_next = entry_reg;
        if (op.insert) begin
            if (keep) begin
                entry_next = entry_reg;
            end else if (left_keep) begin
                entry_next = op.item;
            end else begin
                entry_next = left_entry;
            end
        end else if (op.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

/* test/tb.sv */
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH   = 16;
    localparam int MAX_IDLE      = 12;
    localparam int RESULT_LAT    = 4;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 100;

    // Priorities and values used to fill the queue: extremes and runs of equal priority
    localparam logic [15:0] FILL_PRIO [QUEUE_DEPTH] = '{
        16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h0003, 16'h7FFF,
        16'hFFFF, 16'h0001, 16'h8000, 16'h0002, 16'h0000, 16'h7FFE, 16'h8001, 16'h0005
    };
    localparam logic [31:0] FILL_VALUE [QUEUE_DEPTH] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h0000_0002, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
        32'h1234_5678, 32'h8765_4321, 32'h0000_0003, 32'hDEAD_BEEF,
        32'hCAFE_F00D, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0010
    };
    // Insert share (percent) of each random phase
    localparam int PHASE_INSERT_PCT [RANDOM_PHASES] = '{80, 20, 50, 90, 10, 60, 40};

    typedef struct packed {
        logic [1:0]                   status;
        logic [bmpq_pkg::VALUE_W-1:0] value;
        logic [bmpq_pkg::PRIO_W-1:0]  prio;
        logic [bmpq_pkg::OCC_W-1:0]   occupancy;
    } queue_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [31:0] item_value, [47:32] item_priority
    logic [0:0]  s_tuser;   // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [31:0] removed_value, [47:32] removed_priority,
                            // [52:48] occupancy, [55:53] zero
    logic [1:0]  m_tuser;   // [1:0] status

    bmpq_pkg::entry_t sorted_entries[$];
    queue_result_t    expected_results[$];
    int               mismatch_count = 0;
    int               max_gap = MAX_IDLE;

    bounded_min_priority_queue #(.CAPACITY(QUEUE_DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Apply one accepted command to the sorted copy and queue its result
    task automatic predict_command(input logic cmd, input logic [31:0] value,
                                   input logic [15:0] prio);
        queue_result_t    res;
        bmpq_pkg::entry_t ent;
        int               pos;
        res = '0;
        if (cmd == bmpq_pkg::CMD_INSERT) begin
            if (sorted_entries.size() >= QUEUE_DEPTH) begin
                res.status = bmpq_pkg::STATUS_OVERFLOW;
            end else begin
                pos = 0;
                // Equal priorities: place behind every stored entry of the same priority
                while (pos < sorted_entries.size() &&
                       $signed(sorted_entries[pos].prio) <= $signed(prio))
                    pos++;
                ent.prio  = prio;
                ent.value = value;
                sorted_entries.insert(pos, ent);
                res.status = bmpq_pkg::STATUS_DONE;
            end
        end else begin
            if (sorted_entries.size() == 0) begin
                res.status = bmpq_pkg::STATUS_UNDERFLOW;
            end else begin
                ent = sorted_entries.pop_front();
                res.status = bmpq_pkg::STATUS_DONE;
                res.value  = ent.value;
                res.prio   = ent.prio;
            end
        end
        res.occupancy = bmpq_pkg::OCC_W'(sorted_entries.size());
        expected_results.push_back(res);
    endtask

    // Drive one command after a random gap and wait for its transaction
    task automatic send_command(input logic cmd, input logic [31:0] value,
                                input logic [15:0] prio);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, value};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(cmd, value, prio);
    endtask

    // Hold the sender until every outstanding result has been checked
    task automatic wait_for_results();
        int n;
        s_tvalid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && expected_results.size() > 0; n++)
            @(posedge aclk);
        if (expected_results.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        repeat (RESULT_LAT) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_priority();
        case ($urandom_range(0, 3))
            0: pick_priority = 16'($signed($urandom_range(0, 6)) - 3);
            1: pick_priority = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
            default: pick_priority = 16'($urandom());
        endcase
    endfunction

    task automatic test_remove_empty();
        send_command(bmpq_pkg::CMD_REMOVE, $urandom(), 16'($urandom()));
    endtask

    task automatic test_fill_ties_extremes();
        int i;
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_command(bmpq_pkg::CMD_INSERT, FILL_VALUE[i], FILL_PRIO[i]);
    endtask

    task automatic test_insert_when_full();
        send_command(bmpq_pkg::CMD_INSERT, 32'h0BAD_0BAD, 16'h8000);
    endtask

    task automatic test_remove_in_order();
        repeat (6) send_command(bmpq_pkg::CMD_REMOVE, $urandom(), 16'($urandom()));
    endtask

    task automatic test_random_traffic();
        int ph;
        int k;
        logic cmd;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            // Alternate busy phases with phases that idle on both sides
            max_gap = (ph % 2 == 0) ? MAX_IDLE : 0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                cmd = ($urandom_range(1, 100) <= PHASE_INSERT_PCT[ph])
                    ? bmpq_pkg::CMD_INSERT : bmpq_pkg::CMD_REMOVE;
                send_command(cmd, $urandom(), pick_priority());
            end
            if (ph % 3 == 2)
                wait_for_results();
        end
        max_gap = MAX_IDLE;
    endtask

    // Draw a stall for every result on the receiving side
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result tuser=%h tdata=%h",
                                          m_tuser, m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tuser, want.status));
                if (m_tdata[31:0] !== want.value)
                    report_mismatch($sformatf("removed_value %h, expected %h",
                                              m_tdata[31:0], want.value));
                if (m_tdata[47:32] !== want.prio)
                    report_mismatch($sformatf("removed_priority %h, expected %h",
                                              m_tdata[47:32], want.prio));
                if (m_tdata[52:48] !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              m_tdata[52:48], want.occupancy));
                if (m_tdata[55:53] !== 3'b000)
                    report_mismatch($sformatf("padding bits %b not zero", m_tdata[55:53]));
            end
        end
    end

    // Guard against a hung handshake
    initial begin
        #1_000_000;
        $display("FAIL bounded_min_priority_queue");
        $finish;
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= bmpq_pkg::CMD_INSERT;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_remove_empty();
        test_fill_ties_extremes();
        test_insert_when_full();
        test_remove_in_order();
        wait_for_results();
        test_random_traffic();
        wait_for_results();

        if (mismatch_count == 0) begin
            $display("PASS bounded_min_priority_queue");
        end else begin
            $display("FAIL bounded_min_priority_queue");
        end
        $finish;
    end

endmodule
